>>> design/phase_shift_gray_code_unwrap_unit_macros.svh
// Assertion macros for the phase-shift Gray-code unwrap unit.
// Expects signals clk and rst_n in the scope of use.
`ifndef PHASE_SHIFT_GRAY_CODE_UNWRAP_UNIT_MACROS_SVH
`define PHASE_SHIFT_GRAY_CODE_UNWRAP_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define PSGCU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psgcu check failed");

// Consequent must hold in the cycle after the antecedent
`define PSGCU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psgcu check failed");

`endif

>>> design/psgcu_pkg.sv
// Shared types and constant tables for the phase-shift Gray-code unwrap unit.
// No dependencies; used by front, queue, back and the top level.
`default_nettype none

package psgcu_pkg;

    // Field and datapath widths
    localparam int SAMPLE_W  = 12;
    localparam int ACC_W     = 32;
    localparam int SUM_W     = 16;
    localparam int CODE_W    = 10;
    localparam int CX_W      = 50;
    localparam int ITERS     = 30;
    localparam int DIV_STEPS = 20;
    localparam int Q_DEPTH   = 2;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_PHASE_STEPS       = 2'd0,
        REG_GRAY_IMAGES       = 2'd1,
        REG_TEXTURE_THRESHOLD = 2'd2,
        REG_NONE              = 2'd3
    } reg_index_t;

    // Pixel summary handed from front to back
    typedef struct packed {
        logic [ACC_W-1:0]  sin_acc;
        logic [ACC_W-1:0]  cos_acc;
        logic [SUM_W-1:0]  sum;
        logic [CODE_W-1:0] code;
        logic [3:0]        steps;
        logic [3:0]        grays;
        logic [11:0]       thr;
    } desc_t;

    // Q1.15 cosine of 2*pi*k/N, row N, column k
    localparam logic signed [15:0] COS_TBL [0:12][0:11] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{32767, -16384, -16384, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{32767, 0, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{32767, 10126, -26510, -26510, 10126, 0, 0, 0, 0, 0, 0, 0},
        '{32767, 16384, -16384, -32768, -16384, 16384, 0, 0, 0, 0, 0, 0},
        '{32767, 20431, -7292, -29523, -29523, -7292, 20431, 0, 0, 0, 0, 0},
        '{32767, 23170, 0, -23170, -32768, -23170, 0, 23170, 0, 0, 0, 0},
        '{32767, 25102, 5690, -16384, -30792, -30792, -16384, 5690, 25102, 0, 0, 0},
        '{32767, 26510, 10126, -10126, -26510, -32768, -26510, -10126, 10126, 26510,
          0, 0},
        '{32767, 27566, 13612, -4663, -21458, -31441, -31441, -21458, -4663, 13612,
          27566, 0},
        '{32767, 28378, 16384, 0, -16384, -28378, -32768, -28378, -16384, 0,
          16384, 28378}
    };

    // Q1.15 sine of 2*pi*k/N, row N, column k
    localparam logic signed [15:0] SIN_TBL [0:12][0:11] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 28378, -28378, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 32767, 0, -32768, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 31164, 19261, -19261, -31164, 0, 0, 0, 0, 0, 0, 0},
        '{0, 28378, 28378, 0, -28378, -28378, 0, 0, 0, 0, 0, 0},
        '{0, 25619, 31946, 14218, -14218, -31946, -25619, 0, 0, 0, 0, 0},
        '{0, 23170, 32767, 23170, 0, -23170, -32768, -23170, 0, 0, 0, 0},
        '{0, 21063, 32270, 28378, 11207, -11207, -28378, -32270, -21063, 0, 0, 0},
        '{0, 19261, 31164, 31164, 19261, 0, -19261, -31164, -31164, -19261, 0, 0},
        '{0, 17716, 29807, 32434, 24764, 9232, -9232, -24764, -32434, -29807,
          -17716, 0},
        '{0, 16384, 28378, 32767, 28378, 16384, 0, -16384, -28378, -32768,
          -28378, -16384}
    };

    // CORDIC angles, 2^32 units per turn
    localparam logic [31:0] ATAN_TBL [0:ITERS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
    };

endpackage

`default_nettype wire

>>> design/phase_shift_gray_code_unwrap_unit.sv
// Phase-shift plus Gray-code unwrap unit. Each pixel arrives as N phase
// samples then M Gray samples (N, M from the configuration registers). The
// front part takes a sample only once it is done with the last, multiplying it
// by the tabled sine and cosine and thresholding Gray samples against the mean.
// Each pixel summary goes through a two-entry queue to the back part, which
// takes the summary, runs a 30-step vectoring CORDIC (one step a cycle, with
// the serial mean divider alongside), then rounds and then unwraps; it takes
// no new summary until its result is in the output register.
// A result is presented on m_axis with pixel_valid in tuser and waits there
// until taken.
// Depends on psgcu_pkg, psgcu_front, psgcu_queue and psgcu_back.
`default_nettype none

module phase_shift_gray_code_unwrap_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [25:0] unwrapped_phase,
                                        // [42:26] wrapped_phase,
                                        // [58:43] texture_mean
    output logic [0:0]  m_axis_tuser,   // [0] pixel_valid
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    logic [3:0]         phase_steps_reg;
    logic [3:0]         gray_images_reg;
    logic [11:0]        texture_threshold_reg;
    logic [3:0]         steps;
    logic [3:0]         grays;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;
    psgcu_pkg::desc_t   q_wr;
    psgcu_pkg::desc_t   q_rd;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_steps_reg       <= 4'd4;
            gray_images_reg       <= 4'd5;
            texture_threshold_reg <= 12'd10;
        end
        else if (cfg_we)
        begin
            case (psgcu_pkg::reg_index_t'(cfg_index))
                psgcu_pkg::REG_PHASE_STEPS:       phase_steps_reg <= cfg_data[3:0];
                psgcu_pkg::REG_GRAY_IMAGES:       gray_images_reg <= cfg_data[3:0];
                psgcu_pkg::REG_TEXTURE_THRESHOLD: texture_threshold_reg <= cfg_data;
                default:                          phase_steps_reg <= phase_steps_reg;
            endcase
        end
    end

    // Clamp counts to their legal ranges
    assign steps = (phase_steps_reg < 4'd3)  ? 4'd3  :
                   (phase_steps_reg > 4'd12) ? 4'd12 : phase_steps_reg;
    assign grays = (gray_images_reg < 4'd1)  ? 4'd1  :
                   (gray_images_reg > 4'd10) ? 4'd10 : gray_images_reg;

    psgcu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .steps    (steps),
        .grays    (grays),
        .thr      (texture_threshold_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wr)
    );

    psgcu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd),
        .empty   (q_empty)
    );

    psgcu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_data   (q_rd),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

>>> design/psgcu_front.sv
// Front part: takes samples, accumulates phase sums and builds the Gray code.
// Depends on psgcu_pkg; pushes one pixel summary per pixel into the queue.
`default_nettype none

module psgcu_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,    // [11:0] sample
    input  logic [3:0]          steps,
    input  logic [3:0]          grays,
    input  logic [11:0]         thr,
    input  logic                q_full,
    output logic                q_push,
    output psgcu_pkg::desc_t    q_data
);

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_WORK = 2'b10
    } fstate_t;

    fstate_t                           state_reg;
    logic [psgcu_pkg::SAMPLE_W-1:0]    sample_reg;
    logic signed [15:0]                cos_reg;
    logic signed [15:0]                sin_reg;
    logic                              phase_reg;
    logic                              last_reg;
    logic [4:0]                        count_reg;
    logic [psgcu_pkg::ACC_W-1:0]       sin_acc_reg;
    logic [psgcu_pkg::ACC_W-1:0]       cos_acc_reg;
    logic [psgcu_pkg::SUM_W-1:0]       sum_reg;
    logic [psgcu_pkg::CODE_W-1:0]      code_reg;
    logic                              prev_reg;

    logic                              accept;
    logic [4:0]                        end_count;
    logic signed [28:0]                sin_prod;
    logic signed [28:0]                cos_prod;
    logic [15:0]                       n_times_s;
    logic                              prev_next;
    logic [psgcu_pkg::CODE_W-1:0]      code_next;

    assign s_tready  = (state_reg == F_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign end_count = 5'({1'b0, steps} + {1'b0, grays} - 5'd1);

    // Multiply the held sample by its coefficients
    assign sin_prod  = sin_reg * $signed({1'b0, sample_reg});
    assign cos_prod  = cos_reg * $signed({1'b0, sample_reg});

    // Threshold the Gray sample against the mean and extend the code
    assign n_times_s = 16'(steps * sample_reg);
    assign prev_next = prev_reg ^ (n_times_s >= sum_reg);
    assign code_next = {code_reg[psgcu_pkg::CODE_W-2:0], prev_next};

    assign q_push = (state_reg == F_WORK) && !phase_reg && last_reg && !q_full;

    always_comb
    begin
        q_data.sin_acc = sin_acc_reg;
        q_data.cos_acc = cos_acc_reg;
        q_data.sum     = sum_reg;
        q_data.code    = code_next;
        q_data.steps   = steps;
        q_data.grays   = grays;
        q_data.thr     = thr;
    end

    // Control and pixel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            count_reg   <= '0;
            sin_acc_reg <= '0;
            cos_acc_reg <= '0;
            sum_reg     <= '0;
            code_reg    <= '0;
            prev_reg    <= 1'b0;
            phase_reg   <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        phase_reg <= (count_reg < {1'b0, steps});
                        last_reg  <= (count_reg >= end_count);
                        state_reg <= F_WORK;
                    end
                end
                F_WORK:
                begin
                    if (phase_reg)
                    begin
                        sin_acc_reg <= sin_acc_reg + 32'(sin_prod);
                        cos_acc_reg <= cos_acc_reg + 32'(cos_prod);
                        sum_reg     <= sum_reg + 16'(sample_reg);
                        count_reg   <= count_reg + 5'd1;
                        state_reg   <= F_IDLE;
                    end
                    else if (!last_reg)
                    begin
                        prev_reg  <= prev_next;
                        code_reg  <= code_next;
                        count_reg <= count_reg + 5'd1;
                        state_reg <= F_IDLE;
                    end
                    else if (!q_full)
                    begin
                        // Pixel handed over: clear for the next one
                        prev_reg    <= 1'b0;
                        code_reg    <= '0;
                        count_reg   <= '0;
                        sin_acc_reg <= '0;
                        cos_acc_reg <= '0;
                        sum_reg     <= '0;
                        state_reg   <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    // Hold the sample and its table coefficients
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= s_tdata[psgcu_pkg::SAMPLE_W-1:0];
            cos_reg    <= psgcu_pkg::COS_TBL[steps][count_reg[3:0]];
            sin_reg    <= psgcu_pkg::SIN_TBL[steps][count_reg[3:0]];
        end
    end

endmodule

`default_nettype wire

>>> design/psgcu_queue.sv
// Two-entry queue of pixel summaries between the front and back parts.
// Depends on psgcu_pkg for the summary type and depth.
`default_nettype none

module psgcu_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  psgcu_pkg::desc_t    wr_data,
    output logic                full,
    input  logic                pop,
    output psgcu_pkg::desc_t    rd_data,
    output logic                empty
);

    psgcu_pkg::desc_t  entry_reg [psgcu_pkg::Q_DEPTH];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        cnt_reg;

    assign full    = (cnt_reg == 2'(psgcu_pkg::Q_DEPTH));
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = entry_reg[rd_ptr_reg];

    // Advance pointers and the fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push && !full, pop && !empty})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    // Store the incoming item
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> design/psgcu_back.sv
// Back part: vectoring CORDIC for the wrapped phase, serial divider for the
// mean, unwrap and output register. Depends on psgcu_pkg.
`default_nettype none

module psgcu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    output logic                q_pop,
    input  psgcu_pkg::desc_t    q_data,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [63:0]         m_tdata,
    output logic [0:0]          m_tuser
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_ROT  = 4'b0010,
        B_FIN  = 4'b0100,
        B_OUT  = 4'b1000
    } bstate_t;

    localparam int CW = psgcu_pkg::CX_W;

    bstate_t                        state_reg;
    logic signed [CW-1:0]           x_reg;
    logic signed [CW-1:0]           y_reg;
    logic [31:0]                    z_reg;
    logic [4:0]                     it_reg;
    logic [19:0]                    div_reg;
    logic [3:0]                     rem_reg;
    logic [19:0]                    quot_reg;
    logic [3:0]                     steps_reg;
    logic [3:0]                     grays_reg;
    logic [11:0]                    thr_reg;
    logic [15:0]                    sum_reg;
    logic [psgcu_pkg::CODE_W-1:0]   code_reg;
    logic signed [16:0]             wrap_reg;
    logic                           valid_reg;
    logic                           out_valid_reg;
    logic [25:0]                    unwrap_out_reg;
    logic [16:0]                    wrap_out_reg;
    logic [15:0]                    mean_out_reg;
    logic                           pix_out_reg;

    logic signed [CW-1:0]           c_init;
    logic signed [CW-1:0]           s_init;
    logic signed [CW-1:0]           dx;
    logic signed [CW-1:0]           dy;
    logic                           y_pos;
    logic                           y_neg;
    logic [4:0]                     div_trial;
    logic                           div_ge;
    logic [32:0]                    negz;
    logic [33:0]                    turn_sum;
    logic [17:0]                    wrap_wide;
    logic [15:0]                    thr_n;
    logic [psgcu_pkg::CODE_W-1:0]   gray_mask;
    logic [psgcu_pkg::CODE_W-1:0]   code_v;
    logic [10:0]                    k1;
    logic [10:0]                    k2;
    logic [10:0]                    k_sel;
    logic [25:0]                    unwrap_val;
    logic                           out_free;
    logic                           out_valid_next;

    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign out_free = !out_valid_reg || m_tready;

    // Load a new result, or drop the held one once taken
    assign out_valid_next = ((state_reg == B_OUT) && out_free) ? 1'b1
                                                               : (out_valid_reg && !m_tready);

    // Scale the sums by 2^16 for the CORDIC
    assign c_init = $signed({{2{q_data.cos_acc[31]}}, q_data.cos_acc, 16'b0});
    assign s_init = $signed({{2{q_data.sin_acc[31]}}, q_data.sin_acc, 16'b0});

    // One vectoring step
    assign dx    = y_reg >>> it_reg;
    assign dy    = x_reg >>> it_reg;
    assign y_pos = !y_reg[CW-1] && (y_reg != '0);
    assign y_neg = y_reg[CW-1];

    // One restoring division step
    assign div_trial = {rem_reg, div_reg[19]};
    assign div_ge    = (div_trial >= {1'b0, steps_reg});

    // Negate the angle and round to 2^16 units per turn
    assign negz      = 33'd0 - {z_reg[31], z_reg};
    assign turn_sum  = {negz[32], negz} + 34'h1_0000_0000 + 34'h0_0000_8000;
    assign wrap_wide = turn_sum[33:16] - 18'd65536;
    assign thr_n     = 16'(thr_reg * steps_reg);

    // Pick the period index and form the absolute phase
    always_comb
    begin
        for (int j = 0; j < psgcu_pkg::CODE_W; j++)
        begin
            gray_mask[j] = (j < int'(grays_reg));
        end
        code_v = code_reg & gray_mask;
        k1     = {2'b0, code_v[psgcu_pkg::CODE_W-1:1]};
        k2     = 11'(({1'b0, code_v} + 11'd1) >> 1);
        if (wrap_reg <= -17'sd16384)
        begin
            k_sel = k2;
        end
        else if (wrap_reg >= 17'sd16384)
        begin
            k_sel = k2 - 11'd1;
        end
        else
        begin
            k_sel = k1;
        end
        unwrap_val = valid_reg ? ({k_sel[9:0], 16'b0} + 26'(wrap_reg)) : 26'd0;
    end

    // Sequence one pixel through the shared units
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            it_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        it_reg    <= '0;
                        state_reg <= B_ROT;
                    end
                end
                B_ROT:
                begin
                    it_reg <= it_reg + 5'd1;
                    if (it_reg == 5'(psgcu_pkg::ITERS - 1))
                    begin
                        state_reg <= B_FIN;
                    end
                end
                B_FIN:
                begin
                    state_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    steps_reg <= q_data.steps;
                    grays_reg <= q_data.grays;
                    thr_reg   <= q_data.thr;
                    sum_reg   <= q_data.sum;
                    code_reg  <= q_data.code;
                    div_reg   <= {q_data.sum, 4'b0};
                    rem_reg   <= '0;
                    quot_reg  <= '0;
                    if (c_init < 0)
                    begin
                        x_reg <= -c_init;
                        y_reg <= -s_init;
                        z_reg <= 32'h8000_0000;
                    end
                    else
                    begin
                        x_reg <= c_init;
                        y_reg <= s_init;
                        z_reg <= 32'h0;
                    end
                end
            end
            B_ROT:
            begin
                if (y_pos)
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + psgcu_pkg::ATAN_TBL[it_reg];
                end
                else if (y_neg)
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - psgcu_pkg::ATAN_TBL[it_reg];
                end
                if (it_reg < 5'(psgcu_pkg::DIV_STEPS))
                begin
                    div_reg  <= {div_reg[18:0], 1'b0};
                    rem_reg  <= div_ge ? 4'(div_trial - {1'b0, steps_reg})
                                       : div_trial[3:0];
                    quot_reg <= {quot_reg[18:0], div_ge};
                end
            end
            B_FIN:
            begin
                wrap_reg  <= $signed(wrap_wide[16:0]);
                valid_reg <= (sum_reg > thr_n);
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    unwrap_out_reg <= unwrap_val;
                    wrap_out_reg   <= wrap_reg;
                    mean_out_reg   <= quot_reg[15:0];
                    pix_out_reg    <= valid_reg;
                end
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, mean_out_reg, wrap_out_reg, unwrap_out_reg};
    assign m_tuser  = pix_out_reg;

endmodule

`default_nettype wire

>>> design/psgcu_checker.sv
// Port-level checks for the phase-shift Gray-code unwrap unit, bound to the
// top level. Depends on phase_shift_gray_code_unwrap_unit_macros.svh.
`default_nettype none

`include "phase_shift_gray_code_unwrap_unit_macros.svh"

module psgcu_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // Hold a stalled result
    `PSGCU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // Invalid pixel carries zero absolute phase
    `PSGCU_ASSERT_SAME(a_zero_invalid, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[25:0] == 26'd0)

    // Valid pixel has a non-zero mean
    `PSGCU_ASSERT_SAME(a_mean_nonzero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[58:43] != 16'd0)

    // Wrapped phase stays within half a turn
    `PSGCU_ASSERT_SAME(a_wrap_range, m_axis_tvalid, (m_axis_tdata[42:41] == 2'b00) || (m_axis_tdata[42:41] == 2'b11) || (m_axis_tdata[42:26] == 17'h08000))

endmodule

bind phase_shift_gray_code_unwrap_unit psgcu_port_checker u_psgcu_port_checker (.*);

`default_nettype wire
